>>> rtl/core/css_pkg.sv
// Package for the channel-scaled sigmoid block: widths, command codes,
// queue entry type and the sigmoid table function. No dependencies.
`timescale 1ns / 1ps
package css_pkg;
   localparam int MaxChannels = 256;
   localparam int SigEntries  = 1024;
   localparam int SigIdxW     = $clog2(SigEntries);
   localparam int ChW         = 8;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_FWD   = 2'd1,
      CMD_BWD   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   localparam logic [1:0] REG_CHANNELS  = 2'd0;
   localparam logic [1:0] REG_PLANE     = 2'd1;
   localparam logic [1:0] REG_UPD_GRAD  = 2'd2;
   localparam logic [1:0] REG_PROPAGATE = 2'd3;

   typedef struct packed {
      cmd_type             cmd;
      logic [ChW-1:0]      chan;
      logic signed [15:0]  x;
      logic [15:0]         slope;
      logic signed [15:0]  g;
      logic [15:0]         y;
      logic                clear;
   } item_type;

   localparam logic signed [47:0] AccMax = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] AccMin = {1'b1, {47{1'b0}}};

   // Unsigned 64-bit quotient by shift and subtract; used only while the
   // sigmoid table is built at elaboration.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      begin
         rem = '0;
         quo = '0;
         for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
               rem = rem - {1'b0, den};
               quo[i] = 1'b1;
            end
         end
         udiv64 = quo;
      end
   endfunction

   // Sigmoid at the center of bin k, via a 12-term series for exp(-t/16)
   // raised to the 16th power, rounded to Q0.16. Evaluated at elaboration.
   function automatic logic [15:0] sig_value(input int k);
      longint c, sum;
      logic [63:0] t, s, term, e, d, num, y;
      begin
         c = longint'(64'(2 * k + 1) << (34 - SigIdxW)) - (longint'(1) << 34);
         t = (c < 0) ? 64'(-c) : 64'(c);
         s = t >> 4;
         term = 64'd1 << 31;
         sum = longint'(1) << 31;
         for (int j = 1; j <= 12; j++) begin
            term = udiv64((term * s) >> 31, 64'(j));
            if ((j & 1) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         e = 64'(sum);
         for (int r = 0; r < 4; r++) e = (e * e) >> 31;
         d = (64'd1 << 31) + e;
         num = ((c >= 0) ? (64'd1 << 31) : e) << 16;
         y = udiv64(num + (d >> 1), d);
         if (y > 64'd65535) y = 64'd65535;
         sig_value = y[15:0];
      end
   endfunction

   typedef logic [15:0] sig_rom_type [SigEntries];

   function automatic sig_rom_type build_sig_rom();
      sig_rom_type rom;
      begin
         for (int k = 0; k < SigEntries; k++) rom[k] = sig_value(k);
         build_sig_rom = rom;
      end
   endfunction

   localparam sig_rom_type SigRom = build_sig_rom();
endpackage

>>> rtl/core/css_ram.sv
// Generic RAM with one write port and one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
module css_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/core/css_front.sv
// Front end: accepts request beats, resolves the element channel from the
// plane and channel counters, and pushes items into a two-entry queue.
// Depends on css_pkg.
`timescale 1ns / 1ps
module css_front import css_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  item_type        in_item,
   input  logic            in_first,
   input  logic [8:0]      channel_count,
   input  logic [16:0]     plane_size,
   output logic            q_valid,
   input  logic            q_pop,
   output item_type        q_item
);
   item_type       q_ff [2];
   item_type       q_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           rd_ff, rd_in;
   logic [16:0]    pos_ff, pos_in;
   logic [ChW-1:0] chan_ff, chan_in;
   logic [8:0]     eff_ch;
   logic [16:0]    eff_pl;
   logic [16:0]    pos_cur;
   logic [8:0]     chan_cur;
   logic           push;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = q_ff[rd_ff];

   always_comb begin
      eff_ch = channel_count;
      if (eff_ch == 9'd0) eff_ch = 9'd1;
      if (eff_ch > 9'(MaxChannels)) eff_ch = 9'(MaxChannels);
      eff_pl = plane_size;
      if (eff_pl == 17'd0) eff_pl = 17'd1;
      if (eff_pl > 17'd65536) eff_pl = 17'd65536;

      pos_cur  = in_first ? 17'd0 : pos_ff;
      chan_cur = in_first ? 9'd0 : {1'b0, chan_ff};
      if (chan_cur >= eff_ch) chan_cur = 9'd0;

      q_in = in_item;
      pos_in = pos_ff;
      chan_in = chan_ff;
      if (in_item.cmd == CMD_FWD || in_item.cmd == CMD_BWD) begin
         q_in.chan = chan_cur[ChW-1:0];
         if (pos_cur + 17'd1 >= eff_pl) begin
            pos_in = 17'd0;
            chan_in = (chan_cur + 9'd1 >= eff_ch) ? '0 : ChW'(chan_cur + 9'd1);
         end else begin
            pos_in = pos_cur + 17'd1;
            chan_in = chan_cur[ChW-1:0];
         end
      end
      if (!push) begin
         pos_in = pos_ff;
         chan_in = chan_ff;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
      rd_in = q_pop ? ~rd_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         pos_ff <= '0;
         chan_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         pos_ff <= pos_in;
         chan_ff <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[rd_ff ^ cnt_ff[0]] <= q_in;
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) cnt_ff <= 2'd2;
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

   property p_pop_valid;
      @(posedge clock) disable iff (reset) q_pop |-> q_valid;
   endproperty
   a_pop_valid: assert property (p_pop_valid) else $error("pop from empty queue");

   property p_chan_range;
      @(posedge clock) disable iff (reset) {1'b0, chan_ff} < 9'(MaxChannels) + 9'd1;
   endproperty
   a_chan_range: assert property (p_chan_range) else $error("channel counter range");
endmodule

>>> rtl/core/css_back.sv
// Back end: sequencer that reads the slope and gradient tables, runs the
// multiplies and the accumulator update, and holds the result beat.
// Depends on css_pkg and css_ram.
`timescale 1ns / 1ps
module css_back import css_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_pop,
   input  item_type            q_item,
   input  logic                upd_grad,
   input  logic                propagate,
   output logic                out_valid,
   input  logic                out_ready,
   output logic signed [47:0]  out_value,
   output logic                out_sat,
   output logic [ChW-1:0]      out_chan
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_MUL1 = 5'b00100,
      ST_MUL2 = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type          st_ff, st_in;
   item_type           it_ff;
   logic               clr_ff, clr_in;
   logic [ChW:0]       clr_idx_ff, clr_idx_in;
   logic signed [31:0] p1_ff, p2_ff;
   logic [15:0]        dq_ff;
   logic [15:0]        rom_ff;
   logic signed [47:0] res_ff, res_in;
   logic               sat_ff, sat_in;
   logic               ov_ff, ov_in;
   logic signed [47:0] ores_ff;
   logic               osat_ff;
   logic [ChW-1:0]     ochan_ff;
   logic [15:0]        slope_rd;
   logic [47:0]        grad_rd;
   logic [ChW-1:0]     rd_chan;
   logic               s_we, g_we;
   logic [ChW-1:0]     s_wa, g_wa;
   logic [15:0]        s_wd;
   logic [47:0]        g_wd;
   logic signed [63:0] gp_full, sp_full;
   logic signed [47:0] gq, sq;
   logic signed [49:0] acc_sum;
   logic signed [27:0] p_cl;
   logic [27:0]        p_off;
   logic [SigIdxW-1:0] sidx;
   logic [16:0]        ym;

   assign q_pop = (st_ff == ST_IDLE) && q_valid && !clr_ff;
   assign out_valid = ov_ff;
   assign out_value = ores_ff;
   assign out_sat   = osat_ff;
   assign out_chan  = ochan_ff;

   // The tables are addressed by the item being popped, then by the item in work.
   assign rd_chan = (st_ff == ST_IDLE) ? q_item.chan : it_ff.chan;

   css_ram #(.Width(16), .Depth(MaxChannels)) u_slope (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(rd_chan), .rd_data(slope_rd));
   css_ram #(.Width(48), .Depth(MaxChannels)) u_grad (
      .clock(clock), .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd),
      .rd_addr(rd_chan), .rd_data(grad_rd));

   always_comb begin
      ym = 17'd65536 - {1'b0, it_ff.y};
      p_cl = (p1_ff < -32'sd134217728) ? 28'sh8000000 :
             (p1_ff > 32'sd134217727) ? 28'sh7FFFFFF : $signed(p1_ff[27:0]);
      p_off = 28'(p_cl) + 28'h8000000;
      sidx = p_off[27 -: SigIdxW];
      gp_full = 64'(p2_ff) * $signed({48'd0, dq_ff});
      sp_full = 64'(p1_ff) * $signed({48'd0, dq_ff});
      gq = 48'((gp_full + 64'sd32768) >>> 16);
      sq = 48'((sp_full + 64'sd32768) >>> 16);
      acc_sum = 50'($signed(grad_rd)) + 50'(gq);

      st_in = st_ff;
      res_in = res_ff;
      sat_in = sat_ff;
      ov_in = (ov_ff && !out_ready);
      clr_in = clr_ff;
      clr_idx_in = clr_idx_ff;
      s_we = 1'b0; s_wa = it_ff.chan; s_wd = it_ff.slope;
      g_we = 1'b0; g_wa = it_ff.chan; g_wd = '0;
      if (clr_ff) begin
         s_we = 1'b1; s_wa = clr_idx_ff[ChW-1:0]; s_wd = 16'd4096;
         g_we = 1'b1; g_wa = clr_idx_ff[ChW-1:0];
         clr_idx_in = clr_idx_ff + (ChW+1)'(1);
         if (clr_idx_ff == (ChW+1)'(MaxChannels - 1)) clr_in = 1'b0;
      end
      case (st_ff)
         ST_IDLE: if (q_pop) st_in = ST_READ;
         ST_READ: begin
            res_in = '0;
            sat_in = 1'b0;
            case (it_ff.cmd)
               CMD_WRITE: begin
                  s_we = 1'b1;
                  st_in = ST_DONE;
               end
               CMD_READ: begin
                  res_in = $signed(grad_rd);
                  sat_in = ($signed(grad_rd) == AccMax) || ($signed(grad_rd) == AccMin);
                  g_we = it_ff.clear;
                  st_in = ST_DONE;
               end
               default: st_in = ST_MUL1;
            endcase
         end
         ST_MUL1: st_in = ST_MUL2;
         ST_MUL2: begin
            if (it_ff.cmd == CMD_FWD) begin
               res_in = 48'(rom_ff);
            end else begin
               if (propagate) res_in = sq;
               if (upd_grad) begin
                  g_we = 1'b1;
                  if (acc_sum > 50'(AccMax)) begin
                     g_wd = AccMax; sat_in = 1'b1;
                  end else if (acc_sum < 50'(AccMin)) begin
                     g_wd = AccMin; sat_in = 1'b1;
                  end else g_wd = acc_sum[47:0];
               end
            end
            st_in = ST_DONE;
         end
         ST_DONE: if (!ov_ff || out_ready) begin
            ov_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         clr_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         clr_ff <= clr_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   // READ forms x*slope (forward) or g*slope and g*x (backward); MUL1 looks
   // up the sigmoid table; DONE moves the result into the output register.
   always_ff @(posedge clock) begin
      if (q_pop) it_ff <= q_item;
      res_ff <= res_in;
      sat_ff <= sat_in;
      if (st_ff == ST_DONE && st_in == ST_IDLE) begin
         ores_ff <= res_ff;
         osat_ff <= sat_ff;
         ochan_ff <= it_ff.chan;
      end
      if (st_ff == ST_READ) begin
         if (it_ff.cmd == CMD_FWD) p1_ff <= it_ff.x * $signed(slope_rd);
         else p1_ff <= it_ff.g * $signed(slope_rd);
         p2_ff <= it_ff.g * it_ff.x;
         dq_ff <= 16'(({16'd0, it_ff.y} * {15'd0, ym}) >> 16);
      end
      if (st_ff == ST_MUL1) rom_ff <= SigRom[sidx];
   end

   property p_valid_hold;
      @(posedge clock) disable iff (reset) out_valid && !out_ready |=> out_valid;
   endproperty
   a_valid_hold: assert property (p_valid_hold) else $error("result dropped");

   property p_no_pop_clear;
      @(posedge clock) disable iff (reset) clr_ff |-> !q_pop;
   endproperty
   a_no_pop_clear: assert property (p_no_pop_clear) else $error("pop during clear");

   property p_state_onehot;
      @(posedge clock) disable iff (reset) $onehot(st_ff);
   endproperty
   a_state_onehot: assert property (p_state_onehot) else $error("state code");
endmodule

>>> rtl/core/channel_scaled_sigmoid.sv
// Top level of the channel-scaled sigmoid: configuration registers,
// front end with its item queue, and back end. Depends on css_pkg, css_front and css_back.
//
// channel  dir  beat payload
// req      in   tdata: command, channel, sample_in, slope_value, grad_in, ...
// rsp      out  tdata: result_value, channel_used; tuser: saturated
// csr      in   index 2 bits, data 17 bits, write enable
//
// Forward and backward items pass the back-end steps pop, table read and
// multiply, sigmoid lookup, accumulate and result hand-off; slope writes
// and gradient reads skip lookup and accumulate. The sequencer handles one
// item at a time. A clearing pass after reset writes every table entry.
// Requests queue up to two items then and while a stalled response holds the back end.
`timescale 1ns / 1ps
module channel_scaled_sigmoid import css_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[1:0], channel[9:2], sample_in[25:10], slope_value[41:26],
   // grad_in[57:42], activation_in[73:58], clear_after[74], zeros above
   input  logic [79:0]  req_tdata,
   // first_of_pass
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_value[47:0], channel_used[55:48]
   output logic [55:0]  rsp_tdata,
   // saturated
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [16:0]  csr_data
);
   logic [8:0]  chn_ff;
   logic [16:0] pl_ff;
   logic        upd_ff, prop_ff;
   item_type    in_item, q_item;
   logic        q_valid, q_pop;
   logic signed [47:0] value;
   logic [ChW-1:0] chan;

   always_ff @(posedge clock) begin
      if (reset) begin
         chn_ff <= 9'd1; pl_ff <= 17'd1; upd_ff <= 1'b1; prop_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_CHANNELS:  chn_ff <= csr_data[8:0];
            REG_PLANE:     pl_ff <= csr_data;
            REG_UPD_GRAD:  upd_ff <= csr_data[0];
            REG_PROPAGATE: prop_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign in_item.cmd   = cmd_type'(req_tdata[1:0]);
   assign in_item.chan  = req_tdata[9:2];
   assign in_item.x     = $signed(req_tdata[25:10]);
   assign in_item.slope = req_tdata[41:26];
   assign in_item.g     = $signed(req_tdata[57:42]);
   assign in_item.y     = req_tdata[73:58];
   assign in_item.clear = req_tdata[74];

   css_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(in_item), .in_first(req_tuser), .channel_count(chn_ff),
      .plane_size(pl_ff), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item));

   css_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_item(q_item), .upd_grad(upd_ff), .propagate(prop_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_value(value),
      .out_sat(rsp_tuser), .out_chan(chan));

   assign rsp_tdata = {chan, value};
endmodule

>>> verif/css_checker.sv
// Checker for the channel-scaled sigmoid: watches the request and response
// channels and the register port, predicts each response and compares it.
// Depends on css_pkg.
`timescale 1ns / 1ps
module css_checker import css_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic signed [47:0] value;
      logic               sat;
      logic [7:0]         chan;
   } answer_type;

   logic [15:0]        sig_table [SigEntries];
   logic [15:0]        slopes [MaxChannels];
   logic signed [47:0] grads [MaxChannels];
   int unsigned        pos, cur_chan, n_chan, n_plane;
   logic               upd_grad, propagate;
   answer_type         expected_q [$];

   // Sigmoid at the center of bin k: series for exp(-t/16), raised to the 16th.
   function automatic logic [15:0] bin_sigmoid(int k);
      longint c, sum;
      logic [63:0] t, s, term, e, d, num, y;
      c = longint'((64'(2 * k + 1) << 34) / 64'(SigEntries)) - (longint'(1) << 34);
      t = (c < 0) ? 64'(-c) : 64'(c);
      s = t >> 4;
      term = 64'd1 << 31;
      sum = longint'(1) << 31;
      for (int j = 1; j <= 12; j++) begin
         term = ((term * s) >> 31) / 64'(j);
         if (j % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      e = 64'(sum);
      for (int r = 0; r < 4; r++) e = (e * e) >> 31;
      d = (64'd1 << 31) + e;
      num = ((c >= 0) ? (64'd1 << 31) : e) << 16;
      y = (num + d / 64'd2) / d;
      if (y > 64'd65535) y = 64'd65535;
      return y[15:0];
   endfunction

   // Q8.40 to Q8.24, nearest with ties upward; >>> floors.
   function automatic longint round_q24(longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic answer_type predict_response(logic [79:0] d, logic first);
      answer_type a;
      cmd_type cmd;
      logic [7:0] ch;
      longint x, sl, g, y, dq, p, acc;
      cmd = cmd_type'(d[1:0]);
      ch = d[9:2];
      x = longint'($signed(d[25:10]));
      a = '0;
      a.chan = ch;
      case (cmd)
         CMD_WRITE: slopes[ch] = d[41:26];
         CMD_READ: begin
            a.value = grads[ch];
            a.sat = (grads[ch] == AccMax) || (grads[ch] == AccMin);
            if (d[74]) grads[ch] = '0;
         end
         default: begin
            if (first) begin
               pos = 0;
               cur_chan = 0;
            end
            if (cur_chan >= n_chan) cur_chan = 0;
            a.chan = cur_chan[7:0];
            sl = longint'($signed(slopes[cur_chan]));
            if (cmd == CMD_FWD) begin
               p = x * sl;
               if (p < -(longint'(1) << 27)) p = -(longint'(1) << 27);
               if (p > (longint'(1) << 27) - 1) p = (longint'(1) << 27) - 1;
               a.value = 48'(sig_table[((p + (longint'(1) << 27)) * SigEntries) >> 28]);
            end else begin
               g = longint'($signed(d[57:42]));
               y = longint'(d[73:58]);
               dq = (y * (65536 - y)) >> 16;
               if (propagate) a.value = 48'(round_q24(g * sl * dq));
               if (upd_grad) begin
                  acc = longint'(grads[cur_chan]) + round_q24(g * x * dq);
                  if (acc > longint'(AccMax)) begin
                     acc = longint'(AccMax);
                     a.sat = 1'b1;
                  end else if (acc < longint'(AccMin)) begin
                     acc = longint'(AccMin);
                     a.sat = 1'b1;
                  end
                  grads[cur_chan] = 48'(acc);
               end
            end
            pos++;
            if (pos >= n_plane) begin
               pos = 0;
               cur_chan++;
               if (cur_chan >= n_chan) cur_chan = 0;
            end
         end
      endcase
      return a;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      for (int k = 0; k < SigEntries; k++) sig_table[k] = bin_sigmoid(k);
      fail_count = 0;
   end

   assign pending = expected_q.size();

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         for (int i = 0; i < MaxChannels; i++) begin
            slopes[i] = 16'd4096;
            grads[i] = '0;
         end
         pos = 0;
         cur_chan = 0;
         n_chan = 1;
         n_plane = 1;
         upd_grad = 1'b1;
         propagate = 1'b1;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CHANNELS: begin
                  n_chan = csr_data[8:0];
                  if (n_chan == 0) n_chan = 1;
                  if (n_chan > MaxChannels) n_chan = MaxChannels;
               end
               REG_PLANE: begin
                  n_plane = csr_data;
                  if (n_plane == 0) n_plane = 1;
                  if (n_plane > 65536) n_plane = 65536;
               end
               REG_UPD_GRAD:  upd_grad = csr_data[0];
               REG_PROPAGATE: propagate = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $display("[%0t] response beat with nothing expected", $realtime);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if ($signed(rsp_tdata[47:0]) != want.value)
                  report_mismatch("result_value", $signed(rsp_tdata[47:0]), want.value);
               if (rsp_tuser != want.sat)
                  report_mismatch("saturated", rsp_tuser, want.sat);
               if (rsp_tdata[55:48] != want.chan)
                  report_mismatch("channel_used", rsp_tdata[55:48], want.chan);
            end
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(predict_response(req_tdata, req_tuser));
      end
   end
endmodule

>>> verif/channel_scaled_sigmoid_test.sv
// Test top for the channel-scaled sigmoid: clock, reset, register setup,
// directed and random request beats with random stalls, and the verdict.
// Depends on css_pkg, channel_scaled_sigmoid and css_checker.
`timescale 1ns / 1ps
module channel_scaled_sigmoid_test import css_pkg::*;;
   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [79:0] req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tuser;
   logic [55:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [16:0] csr_data;
   int          fail_count, pending;
   bit          quiet;
   int          n_chan_cfg;

   channel_scaled_sigmoid dut (.*);
   css_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Response side stalls in random bursts.
   initial begin
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // The beat stays valid after acceptance until the next beat or a drain.
   task automatic send_beat(cmd_type cmd, logic [7:0] ch, logic first, logic [15:0] x,
                            logic [15:0] sl, logic [15:0] g, logic [15:0] y, logic clr);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, clr, y, g, sl, x, ch, cmd};
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [16:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
   endtask

   task automatic drain_then_settle();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_beat();
      int kind;
      logic [7:0] ch;
      logic [15:0] r0, r1, r2, r3;
      logic rc;
      kind = $urandom_range(0, 99);
      ch = 8'($urandom_range(0, n_chan_cfg - 1));
      r0 = 16'($urandom);
      r1 = 16'($urandom);
      r2 = 16'($urandom);
      r3 = 16'($urandom);
      rc = 1'($urandom);
      if (kind < 8)
         send_beat(CMD_WRITE, ch, 1'b0, r0, r1, r2, r3, rc);
      else if (kind < 14)
         send_beat(CMD_READ, ch, 1'b0, r0, r1, r2, r3, rc);
      else
         send_beat(kind < 55 ? CMD_FWD : CMD_BWD, 8'($urandom), $urandom_range(0, 30) == 0,
                   r0, r1, r2, r3, rc);
   endtask

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_CHANNELS;
      csr_data = '0;
      n_chan_cfg = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults first, then extremes of every field.
      send_beat(CMD_FWD, 8'd0, 1, 16'h0000, 0, 0, 0, 0);
      send_beat(CMD_FWD, 8'd0, 0, 16'h7FFF, 0, 0, 0, 0);
      send_beat(CMD_FWD, 8'd0, 0, 16'h8000, 0, 0, 0, 0);
      send_beat(CMD_WRITE, 8'd255, 0, 0, 16'h8000, 0, 0, 0);
      send_beat(CMD_WRITE, 8'd0, 0, 0, 16'h7FFF, 0, 0, 0);
      send_beat(CMD_FWD, 8'd0, 0, 16'h7FFF, 0, 0, 0, 0);
      send_beat(CMD_FWD, 8'd0, 0, 16'h8000, 0, 0, 0, 0);
      send_beat(CMD_BWD, 8'd0, 0, 16'h7FFF, 0, 16'h7FFF, 16'h8000, 0);
      send_beat(CMD_BWD, 8'd0, 0, 16'h8000, 0, 16'h7FFF, 16'hFFFF, 0);
      send_beat(CMD_BWD, 8'd0, 0, 16'h8000, 0, 16'h8000, 16'h0001, 0);
      send_beat(CMD_READ, 8'd0, 0, 0, 0, 0, 0, 1);
      send_beat(CMD_READ, 8'd0, 0, 0, 0, 0, 0, 0);
      // Accumulate the largest positive gradient steps on channel 0.
      for (int i = 0; i < 12; i++)
         send_beat(CMD_BWD, 8'd0, 0, 16'h8000, 0, 16'h8000, 16'h8000, 0);
      send_beat(CMD_READ, 8'd0, 0, 0, 0, 0, 0, 1);
      drain_then_settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin n_chan_cfg = 3;   write_reg(REG_CHANNELS, 17'd3);
                                       write_reg(REG_PLANE, 17'd2); end
            1: begin n_chan_cfg = 256; write_reg(REG_CHANNELS, 17'h1FF);
                                       write_reg(REG_PLANE, 17'd0);
                                       write_reg(REG_UPD_GRAD, 17'd0); end
            2: begin n_chan_cfg = 1;   write_reg(REG_CHANNELS, 17'd0);
                                       write_reg(REG_PLANE, 17'h1FFFF);
                                       write_reg(REG_PROPAGATE, 17'd0);
                                       write_reg(REG_UPD_GRAD, 17'd1); end
            3: begin n_chan_cfg = 256; write_reg(REG_CHANNELS, 17'd256);
                                       write_reg(REG_PLANE, 17'd1);
                                       write_reg(REG_PROPAGATE, 17'd1); end
            4: begin n_chan_cfg = 5;   write_reg(REG_CHANNELS, 17'd5);
                                       write_reg(REG_PLANE, 17'd7); end
            default: begin n_chan_cfg = 2; write_reg(REG_CHANNELS, 17'd2);
                                       write_reg(REG_PLANE, 17'd65536);
                                       quiet = 1'b1; end
         endcase
         csr_we <= 1'b0;
         for (int i = 0; i < 255; i++) random_beat();
         drain_then_settle();
      end

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

>>> channel_scaled_sigmoid.f
rtl/core/css_pkg.sv
rtl/core/css_ram.sv
rtl/core/css_front.sv
rtl/core/css_back.sv
rtl/core/channel_scaled_sigmoid.sv
verif/css_checker.sv
verif/channel_scaled_sigmoid_test.sv
